>>> src/nli_pkg.sv
// Shared constants, ROM tables and types for the NTC LUT interpolator.
package nli_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADC_BITS      = 12;
    localparam int TEMP_W        = 12;
    localparam int ROM_ENTRIES   = 16;
    localparam int ROM_IDX_W     = $clog2(ROM_ENTRIES);
    localparam int USED_ENTRIES  = (TABLE_ENTRIES < 1) ? 1 :
                                   ((TABLE_ENTRIES < ROM_ENTRIES) ? TABLE_ENTRIES : ROM_ENTRIES);
    localparam int IDX_W         = $clog2(USED_ENTRIES + 1);
    localparam int NUM_W         = TEMP_W + ADC_BITS;
    localparam int CNT_W         = $clog2(NUM_W + 1);

    localparam logic [ADC_BITS-1:0] LUT_ADC_A [ROM_ENTRIES] = '{
        12'd35,  12'd44,  12'd56,  12'd72,  12'd93,  12'd120, 12'd156, 12'd203,
        12'd263, 12'd338, 12'd427, 12'd528, 12'd634, 12'd735, 12'd824, 12'd894
    };
    localparam logic [ADC_BITS-1:0] LUT_ADC_B [ROM_ENTRIES] = '{
        12'd138,  12'd173,  12'd219,  12'd279,  12'd358,  12'd462,  12'd599,  12'd778,
        12'd1009, 12'd1298, 12'd1647, 12'd2045, 12'd2468, 12'd2880, 12'd3245, 12'd3538
    };
    localparam logic signed [TEMP_W-1:0] LUT_TEMP_A [ROM_ENTRIES] = '{
        12'sd2009, 12'sd1859, 12'sd1707, 12'sd1555, 12'sd1404, 12'sd1258, 12'sd1110, 12'sd962,
        12'sd816,  12'sd669,  12'sd524,  12'sd378,  12'sd231,  12'sd86,   -12'sd61,  -12'sd206
    };
    localparam logic signed [TEMP_W-1:0] LUT_TEMP_B [ROM_ENTRIES] = '{
        12'sd2004, 12'sd1857, 12'sd1710, 12'sd1564, 12'sd1418, 12'sd1273, 12'sd1127, 12'sd982,
        12'sd837,  12'sd691,  12'sd546,  12'sd401,  12'sd256,  12'sd110,  -12'sd35,  -12'sd180
    };

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_MULT   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    function automatic logic [ADC_BITS-1:0] rom_adc(input logic sel,
                                                    input logic [ROM_IDX_W-1:0] idx);
        rom_adc = sel ? LUT_ADC_B[idx] : LUT_ADC_A[idx];
    endfunction

    function automatic logic signed [TEMP_W-1:0] rom_temp(input logic sel,
                                                          input logic [ROM_IDX_W-1:0] idx);
        rom_temp = sel ? LUT_TEMP_B[idx] : LUT_TEMP_A[idx];
    endfunction

endpackage

>>> src/nli_sample_if.sv
// Input channel interface carrying one ADC sample per transaction.
interface nli_sample_if import nli_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

>>> src/nli_temp_if.sv
// Output channel interface carrying one temperature per transaction.
interface nli_temp_if import nli_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

>>> src/ntc_lut_linear_interpolator_top.sv
// Top level of the NTC thermistor LUT interpolator.
//
// Usage:
//   sample_ch (sink) takes one 12-bit ADC reading per transaction.
//   temp_ch (source) returns one signed temperature in 1/16 degree C per
//   transaction, in input order.
//   cfg_we/cfg_wdata write table_select (0: B3950 5V table, 1: B3977 5.2V);
//   write it only while the block is idle.
// Operation:
//   A sequencer walks the table one entry per cycle, then a multiply step
//   and a restoring divider that retires one quotient bit per cycle plus
//   a finishing step, then loads the output register once it is free.
//   Samples at or beyond the table ends skip the multiply and divide.
//   The block takes one sample at a time; sample_ch.ready is high only
//   while the sequencer is idle.
// Reset clears the sequencer, the output valid and table_select to 0.
// A stalled receiver holds the result in the output register; a new sample
// may be accepted meanwhile and waits for the register before it finishes.
module ntc_lut_linear_interpolator_top import nli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    nli_sample_if.sink        sample_ch,
    nli_temp_if.source        temp_ch
);

    state_t                     state_reg, state_next;
    logic                       sel_cfg_reg;
    logic                       sel_reg, sel_next;
    logic [ADC_BITS-1:0]        x_reg, x_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [ADC_BITS-1:0]        x0_reg, x0_next;
    logic [ADC_BITS-1:0]        x1_reg, x1_next;
    logic signed [TEMP_W-1:0]   t0_reg, t0_next;
    logic signed [TEMP_W-1:0]   t1_reg, t1_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic [ADC_BITS-1:0]        div_reg, div_next;
    logic [ADC_BITS-1:0]        rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [TEMP_W-1:0]   res_reg, res_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [TEMP_W-1:0]   out_data_reg, out_data_next;

    logic                       in_accept;
    logic                       out_free;
    logic [ADC_BITS-1:0]        cur_adc;
    logic signed [TEMP_W-1:0]   cur_temp;
    logic signed [TEMP_W:0]     dt;
    logic [TEMP_W:0]            dt_mag;
    logic [ADC_BITS:0]          rem_sh;
    logic                       rem_ge;
    logic [TEMP_W-1:0]          quo;

    assign sample_ch.ready     = (state_reg == ST_IDLE);
    assign in_accept           = sample_ch.valid && sample_ch.ready;
    assign out_free            = !out_valid_reg || temp_ch.ready;
    assign temp_ch.valid       = out_valid_reg;
    assign temp_ch.temperature = out_data_reg;

    assign cur_adc  = rom_adc(sel_reg, idx_reg[ROM_IDX_W-1:0]);
    assign cur_temp = rom_temp(sel_reg, idx_reg[ROM_IDX_W-1:0]);

    assign dt     = {t1_reg[TEMP_W-1], t1_reg} - {t0_reg[TEMP_W-1], t0_reg};
    assign dt_mag = dt[TEMP_W] ? (~dt + 1'b1) : dt;
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, div_reg};
    assign quo    = num_reg[TEMP_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && temp_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next     = sample_ch.adc_code;
                    sel_next   = sel_cfg_reg;
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (idx_reg == IDX_W'(USED_ENTRIES))
                begin
                    // past the last entry: hold the last temperature seen
                    res_next   = t0_reg;
                    state_next = ST_DONE;
                end
                else if (x_reg > cur_adc)
                begin
                    x0_next  = cur_adc;
                    t0_next  = cur_temp;
                    idx_next = idx_reg + 1'b1;
                end
                else if (idx_reg == '0)
                begin
                    res_next   = cur_temp;
                    state_next = ST_DONE;
                end
                else if (cur_adc <= x0_reg)
                begin
                    res_next   = cur_temp;
                    state_next = ST_DONE;
                end
                else
                begin
                    x1_next    = cur_adc;
                    t1_next    = cur_temp;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                num_next   = NUM_W'(dt_mag[TEMP_W-1:0]) * NUM_W'(x_reg - x0_reg);
                div_next   = x1_reg - x0_reg;
                neg_next   = dt[TEMP_W];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W))
                begin
                    res_next   = neg_reg ? (t0_reg - $signed(quo)) : (t0_reg + $signed(quo));
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next = rem_ge ? ADC_BITS'(rem_sh - {1'b0, div_reg})
                                      : rem_sh[ADC_BITS-1:0];
                    num_next = {num_reg[NUM_W-2:0], rem_ge};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sel_cfg_reg   <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                sel_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        x_reg        <= x_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        num_reg      <= num_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_SEARCH) && (idx_reg == '0))
        else $error("accepted sample did not start a table search");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (idx_reg <= IDX_W'(USED_ENTRIES)))
        else $error("table index ran past the used entries");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(NUM_W)))
        else $error("divider step count overran");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result was not loaded into the output register");
`endif

endmodule

>>> test/tb_ntc_lut_linear_interpolator_top.sv
// Testbench for ntc_lut_linear_interpolator_top with random and directed samples.
module tb_ntc_lut_linear_interpolator_top;
    import nli_pkg::*;

    localparam int KNOTS          = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam int ADC_KNOTS [2][KNOTS] = '{
        '{35, 44, 56, 72, 93, 120, 156, 203, 263, 338, 427, 528, 634, 735, 824, 894},
        '{138, 173, 219, 279, 358, 462, 599, 778,
          1009, 1298, 1647, 2045, 2468, 2880, 3245, 3538}
    };
    localparam int TEMP_KNOTS [2][KNOTS] = '{
        '{2009, 1859, 1707, 1555, 1404, 1258, 1110, 962,
          816, 669, 524, 378, 231, 86, -61, -206},
        '{2004, 1857, 1710, 1564, 1418, 1273, 1127, 982,
          837, 691, 546, 401, 256, 110, -35, -180}
    };

    typedef struct {
        logic [ADC_BITS-1:0]      adc;
        logic signed [TEMP_W-1:0] temperature;
    } temp_expect_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    nli_sample_if sample_ch();
    nli_temp_if   temp_ch();

    logic [ADC_BITS-1:0] samples_to_send [$];
    temp_expect_t        pending_temps [$];
    logic                table_sel;
    logic                sample_taken = 1'b0;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  holds_requested;
    int                  holds_done = 0;
    int                  hold_left = 0;
    int                  mismatches = 0;

    ntc_lut_linear_interpolator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .temp_ch   (temp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [TEMP_W-1:0] interp_temperature(
        input logic sel, input logic [ADC_BITS-1:0] adc);
        int s;
        int x;
        int i;
        int x0;
        int x1;
        int t0;
        int t1;
        int t;
        s = int'(sel);
        x = int'(adc);
        i = 0;
        while (i < KNOTS && x > ADC_KNOTS[s][i])
            i++;
        if (i >= KNOTS)
            t = TEMP_KNOTS[s][KNOTS-1];
        else if (i == 0)
            t = TEMP_KNOTS[s][0];
        else
        begin
            x0 = ADC_KNOTS[s][i-1];
            x1 = ADC_KNOTS[s][i];
            t0 = TEMP_KNOTS[s][i-1];
            t1 = TEMP_KNOTS[s][i];
            t  = t0 + ((t1 - t0) * (x - x0)) / (x1 - x0);
        end
        return t[TEMP_W-1:0];
    endfunction

    task automatic write_table_select(input logic sel);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sel;
        table_sel  = sel;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // table ends, their neighbors, an inner knot, a midpoint, all-zero/all-one and alternating-bit samples
    task automatic queue_directed(input logic sel);
        int s;
        int picks [12];
        s = int'(sel);
        picks = '{0, 4095, ADC_KNOTS[s][0] - 1, ADC_KNOTS[s][0], ADC_KNOTS[s][0] + 1,
                  ADC_KNOTS[s][7], ADC_KNOTS[s][7] + 1,
                  (ADC_KNOTS[s][14] + ADC_KNOTS[s][15]) / 2,
                  ADC_KNOTS[s][15], ADC_KNOTS[s][15] + 1, 'hAAA, 'h555};
        @(posedge clk);
        foreach (picks[k])
            samples_to_send.push_back(picks[k][ADC_BITS-1:0]);
    endtask

    task automatic queue_random(input int count, input logic sel);
        int s;
        int r;
        int v;
        s = int'(sel);
        @(posedge clk);
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 70)
                v = $urandom_range(ADC_KNOTS[s][KNOTS-1], ADC_KNOTS[s][0]);
            else if (r < 80)
                v = ADC_KNOTS[s][$urandom_range(KNOTS-1)];
            else if (r < 90)
                v = ADC_KNOTS[s][$urandom_range(KNOTS-1)] + $urandom_range(4) - 2;
            else
                v = $urandom_range(4095);
            samples_to_send.push_back(v[ADC_BITS-1:0]);
        end
    endtask

    task automatic drain;
        while (samples_to_send.size() != 0 || sample_ch.valid || pending_temps.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_ch.valid || sample_taken)
            begin
                if (samples_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    sample_ch.adc_code <= samples_to_send.pop_front();
                    sample_ch.valid    <= 1'b1;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
        else
        begin
            sample_ch.valid    <= 1'b0;
            sample_ch.adc_code <= '0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                temp_ch.ready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (holds_requested != holds_done)
            begin
                temp_ch.ready <= 1'b0;
                hold_left     <= HOLD_CYCLES;
                holds_done    <= holds_done + 1;
            end
            else
            begin
                temp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
        else
        begin
            temp_ch.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        temp_expect_t exp_item;
        if (rst_n)
        begin
            sample_taken <= sample_ch.valid && sample_ch.ready;
            if (sample_ch.valid && sample_ch.ready)
            begin
                exp_item.adc         = sample_ch.adc_code;
                exp_item.temperature = interp_temperature(table_sel, sample_ch.adc_code);
                pending_temps.push_back(exp_item);
            end
            if (temp_ch.valid && temp_ch.ready)
            begin
                if (pending_temps.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected transaction: temperature %0d", temp_ch.temperature);
                    mismatches++;
                end
                else
                begin
                    exp_item = pending_temps.pop_front();
                    if (temp_ch.temperature !== exp_item.temperature)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("adc %0d table %0d: expected %0d, got %0d",
                                     exp_item.adc, table_sel, exp_item.temperature,
                                     temp_ch.temperature);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (temp_ch.valid && temp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        table_sel            = 1'b0;
        tx_idle_pct          = 19;
        rx_idle_pct          = 19;
        holds_requested      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_table_select(1'b0);
        queue_directed(1'b0);
        queue_random(400, 1'b0);
        drain();

        // long receiver hold-off while samples keep coming
        write_table_select(1'b1);
        queue_directed(1'b1);
        queue_random(400, 1'b1);
        holds_requested++;
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_table_select(1'b0);
        queue_random(400, 1'b0);
        drain();

        tx_idle_pct = 19;
        rx_idle_pct = 19;
        write_table_select(1'b1);
        queue_random(550, 1'b1);
        drain();

        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_temps.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
src/nli_pkg.sv
src/nli_sample_if.sv
src/nli_temp_if.sv
src/ntc_lut_linear_interpolator_top.sv
test/tb_ntc_lut_linear_interpolator_top.sv
